// File: sv/md5_pkg.sv
// Shared types, constants and round functions of the MD5 stream hasher.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] LAST_POS     = 6'h3F;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] LAST_STEP    = 6'd63;
    localparam logic [1:0] LAST_WORD    = 2'd3;
    localparam logic       CMD_ABSORB   = 1'b0;
    localparam logic       CMD_FINISH   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_COMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } buf_wr_t;

    function automatic logic [31:0] md5_f(input logic [5:0] step, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (step[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] step);
        logic [3:0] g;
        unique case (step[5:4])
            2'd0:    g = step[3:0];
            2'd1:    g = 4'(step[3:0] * 4'd5 + 4'd1);
            2'd2:    g = 4'(step[3:0] * 4'd3 + 4'd5);
            default: g = 4'(step[3:0] * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] step);
        logic [4:0] s;
        unique case ({step[5:4], step[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] md5_k(input logic [5:0] step);
        logic [31:0] k;
        unique case (step)
            6'd0:    k = 32'hd76aa478;
            6'd1:    k = 32'he8c7b756;
            6'd2:    k = 32'h242070db;
            6'd3:    k = 32'hc1bdceee;
            6'd4:    k = 32'hf57c0faf;
            6'd5:    k = 32'h4787c62a;
            6'd6:    k = 32'ha8304613;
            6'd7:    k = 32'hfd469501;
            6'd8:    k = 32'h698098d8;
            6'd9:    k = 32'h8b44f7af;
            6'd10:   k = 32'hffff5bb1;
            6'd11:   k = 32'h895cd7be;
            6'd12:   k = 32'h6b901122;
            6'd13:   k = 32'hfd987193;
            6'd14:   k = 32'ha679438e;
            6'd15:   k = 32'h49b40821;
            6'd16:   k = 32'hf61e2562;
            6'd17:   k = 32'hc040b340;
            6'd18:   k = 32'h265e5a51;
            6'd19:   k = 32'he9b6c7aa;
            6'd20:   k = 32'hd62f105d;
            6'd21:   k = 32'h02441453;
            6'd22:   k = 32'hd8a1e681;
            6'd23:   k = 32'he7d3fbc8;
            6'd24:   k = 32'h21e1cde6;
            6'd25:   k = 32'hc33707d6;
            6'd26:   k = 32'hf4d50d87;
            6'd27:   k = 32'h455a14ed;
            6'd28:   k = 32'ha9e3e905;
            6'd29:   k = 32'hfcefa3f8;
            6'd30:   k = 32'h676f02d9;
            6'd31:   k = 32'h8d2a4c8a;
            6'd32:   k = 32'hfffa3942;
            6'd33:   k = 32'h8771f681;
            6'd34:   k = 32'h6d9d6122;
            6'd35:   k = 32'hfde5380c;
            6'd36:   k = 32'ha4beea44;
            6'd37:   k = 32'h4bdecfa9;
            6'd38:   k = 32'hf6bb4b60;
            6'd39:   k = 32'hbebfbc70;
            6'd40:   k = 32'h289b7ec6;
            6'd41:   k = 32'heaa127fa;
            6'd42:   k = 32'hd4ef3085;
            6'd43:   k = 32'h04881d05;
            6'd44:   k = 32'hd9d4d039;
            6'd45:   k = 32'he6db99e5;
            6'd46:   k = 32'h1fa27cf8;
            6'd47:   k = 32'hc4ac5665;
            6'd48:   k = 32'hf4292244;
            6'd49:   k = 32'h432aff97;
            6'd50:   k = 32'hab9423a7;
            6'd51:   k = 32'hfc93a039;
            6'd52:   k = 32'h655b59c3;
            6'd53:   k = 32'h8f0ccc92;
            6'd54:   k = 32'hffeff47d;
            6'd55:   k = 32'h85845dd1;
            6'd56:   k = 32'h6fa87e4f;
            6'd57:   k = 32'hfe2ce6e0;
            6'd58:   k = 32'ha3014314;
            6'd59:   k = 32'h4e0811a1;
            6'd60:   k = 32'hf7537e82;
            6'd61:   k = 32'hbd3af235;
            6'd62:   k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

// File: sv/md5_buf.sv
// Block buffer: sixteen 32-bit words, byte writes, one registered word read.
module md5_buf (
    input  logic                clk,
    input  md5_pkg::buf_wr_t    wr,
    input  logic [3:0]          raddr,
    output logic [31:0]         rdata
);
    import md5_pkg::*;

    logic [31:0] mem_reg [16];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr[5:2]][{wr.addr[1:0], 3'b000} +: 8] <= wr.data;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/md5_step.sv
// Shared MD5 step unit: computes the new b word of one compression step.
module md5_step (
    input  logic [5:0]  step,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    output logic [31:0] b_new
);
    import md5_pkg::*;

    logic [31:0] sum;
    logic [4:0]  sh;
    logic [63:0] dbl;

    always_comb
    begin
        sum   = a + md5_f(step, b, c, d) + m + md5_k(step);
        sh    = md5_rot(step);
        dbl   = {sum, sum} << sh;
        b_new = b + dbl[63:32];
    end

endmodule

// File: sv/md5_stream_hasher.sv
// Top level of the byte-serial MD5 hasher: sequencer, state and stream ports.
//
// Input channel s_*: each item carries one command. s_tuser = 0 absorbs the
// byte in s_tdata[7:0]; s_tuser = 1 finishes the message (s_tdata ignored).
// Output channel m_*: a finish yields four items, digest words 0..3 with the
// word index in m_tdata[33:32] and m_tlast high on word 3. Each word holds
// digest bytes 4k..4k+3, byte 4k in the low bits.
// Timing: an absorb writes its byte into the block buffer; the byte that fills
// a 64-byte block adds a read-setup state and 64 steps of the shared single-step
// round unit before s_tready returns. A finish writes the padding one byte per
// cycle, runs one or two compressions and then presents the four words.
// s_tready stays low from a finish until the last word is taken; a stalled
// m_tready holds the current word.
// Reset loads the MD5 initial vector and a zero bit count; the block buffer
// needs no clearing since every byte is written before it is read.
module md5_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] digest_word, [33:32] word_index, [39:34] zero
    output logic        m_tlast     // last_word
);
    import md5_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [5:0]  step_reg, step_next;
    logic [5:0]  ptr_reg, ptr_next;
    logic        fin_reg, fin_next;
    logic        extra_reg, extra_next;
    logic [1:0]  idx_reg, idx_next;

    buf_wr_t     wr;
    logic [3:0]  raddr;
    logic [31:0] rdata;
    logic [31:0] b_step;
    logic [5:0]  pos;

    md5_buf u_buf (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    md5_step u_step (
        .step  (step_reg),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .m     (rdata),
        .b_new (b_step)
    );

    assign pos = bitlen_reg[8:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
            bitlen_reg   <= '0;
            step_reg     <= '0;
            ptr_reg      <= '0;
            fin_reg      <= 1'b0;
            extra_reg    <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            chain_reg  <= chain_next;
            bitlen_reg <= bitlen_next;
            step_reg   <= step_next;
            ptr_reg    <= ptr_next;
            fin_reg    <= fin_next;
            extra_reg  <= extra_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        chain_next  = chain_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        bitlen_next = bitlen_reg;
        step_next   = step_reg;
        ptr_next    = ptr_reg;
        fin_next    = fin_reg;
        extra_next  = extra_reg;
        idx_next    = idx_reg;
        wr          = '0;
        raddr       = '0;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    wr.en   = 1'b1;
                    wr.addr = pos;
                    if (s_tuser == CMD_ABSORB)
                    begin
                        wr.data     = s_tdata;
                        bitlen_next = bitlen_reg + 64'd8;
                        fin_next    = 1'b0;
                        if (pos == LAST_POS)
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        wr.data  = PAD_BYTE;
                        fin_next = 1'b1;
                        ptr_next = pos + 6'd1;
                        if (pos == LAST_POS)
                        begin
                            extra_next = 1'b1;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            extra_next = (pos >= LEN_POS);
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                wr.en   = 1'b1;
                wr.addr = ptr_reg;
                if (!extra_reg && (ptr_reg >= LEN_POS))
                begin
                    wr.data = bitlen_reg[{ptr_reg[2:0], 3'b000} +: 8];
                end
                else
                begin
                    wr.data = '0;
                end
                ptr_next = ptr_reg + 6'd1;
                if (ptr_reg == LAST_POS)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                raddr      = md5_g('0);
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                step_next  = '0;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                raddr     = md5_g(step_reg + 6'd1);
                a_next    = d_reg;
                b_next    = b_step;
                c_next    = b_reg;
                d_next    = c_reg;
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    chain_next[0] = chain_reg[0] + d_reg;
                    chain_next[1] = chain_reg[1] + b_step;
                    chain_next[2] = chain_reg[2] + b_reg;
                    chain_next[3] = chain_reg[3] + c_reg;
                    if (!fin_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (extra_reg)
                    begin
                        extra_next = 1'b0;
                        ptr_next   = '0;
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == LAST_WORD)
                    begin
                        chain_next[0] = IV_A;
                        chain_next[1] = IV_B;
                        chain_next[2] = IV_C;
                        chain_next[3] = IV_D;
                        bitlen_next   = '0;
                        fin_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tdata = {6'b0, idx_reg, chain_reg[idx_reg]};
    assign m_tlast = (idx_reg == LAST_WORD);

endmodule

// File: sim/md5_stream_hasher_tb.sv
// Self-checking testbench of the byte-serial MD5 stream hasher.
module md5_stream_hasher_tb;

    import md5_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 600;

    localparam logic [0:63][31:0] ROUND_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [0:15][4:0] ROT_AMOUNT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        is_last;
    } digest_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic        s_tuser;     // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // [31:0] digest_word, [33:32] word_index, [39:34] zero
    logic        m_tlast;     // last_word

    logic [31:0] chain_words [4];
    logic [7:0]  block_bytes [64];
    logic [63:0] msg_bits;

    digest_word_t pending_digest_words [$];

    int error_count;
    int items_sent;
    int burst_left;
    int hold_request;
    int cycle_count;

    md5_stream_hasher DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void load_initial_vector();
        chain_words[0] = IV_A;
        chain_words[1] = IV_B;
        chain_words[2] = IV_C;
        chain_words[3] = IV_D;
        msg_bits       = 64'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, t;
        int g, rnd;
        for (int i = 0; i < 16; i++)
        begin
            m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        for (int i = 0; i < 64; i++)
        begin
            rnd = i / 16;
            case (rnd)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = a + f + m[g] + ROUND_K[i];
            a = d;
            d = c;
            c = b;
            b = b + rotl(t, int'(ROT_AMOUNT[rnd * 4 + (i % 4)]));
        end
        chain_words[0] = chain_words[0] + a;
        chain_words[1] = chain_words[1] + b;
        chain_words[2] = chain_words[2] + c;
        chain_words[3] = chain_words[3] + d;
    endfunction

    function automatic void hash_item(input logic cmd, input logic [7:0] data);
        int pos;
        digest_word_t entry;
        pos = int'(msg_bits[8:3]);
        if (cmd == CMD_ABSORB)
        begin
            block_bytes[pos] = data;
            msg_bits = msg_bits + 64'd8;
            if (pos == 63)
                compress_block();
        end
        else
        begin
            block_bytes[pos] = PAD_BYTE;
            pos++;
            if (pos > int'(LEN_POS))
            begin
                while (pos < 64)
                begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < int'(LEN_POS))
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++)
                block_bytes[int'(LEN_POS) + k] = msg_bits[8*k +: 8];
            compress_block();
            for (int k = 0; k < 4; k++)
            begin
                entry.word    = chain_words[k];
                entry.index   = 2'(k);
                entry.is_last = (k == 3);
                pending_digest_words.push_back(entry);
            end
            load_initial_vector();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch: %s expected %h got %h", what, want, got);
        error_count++;
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hash_item(cmd, data);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(CMD_ABSORB, 8'($urandom));
        send_item(CMD_FINISH, 8'($urandom));
    endtask

    task automatic test_empty_message();
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_FINISH, 8'hFF);
        send_item(CMD_FINISH, 8'h5A);
    endtask

    task automatic test_byte_extremes();
        send_item(CMD_ABSORB, 8'h00);
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_ABSORB, 8'hFF);
        send_item(CMD_FINISH, 8'hFF);
        send_item(CMD_ABSORB, 8'h61);
        send_item(CMD_ABSORB, 8'h62);
        send_item(CMD_ABSORB, 8'h63);
        send_item(CMD_FINISH, 8'hA5);
    endtask

    task automatic test_random_messages();
        int start_items;
        int len;
        start_items = items_sent;
        send_message(55);
        send_message(56);
        send_message(63);
        while (items_sent - start_items < 195)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(30, 70);
            else
                len = $urandom_range(0, 24);
            send_message(len);
        end
    endtask

    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        send_message(8);
        send_message(3);
        send_message(0);
    endtask

    initial
    begin : receiver
        int mode;
        int span;
        int hold_left;
        m_tready = 1'b0;
        mode = 0;
        span = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : digest_check
        digest_word_t head;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digest_words.size() == 0)
            begin
                report_mismatch("unexpected digest word", 32'h0, m_tdata[31:0]);
            end
            else
            begin
                head = pending_digest_words.pop_front();
                if (m_tdata[31:0] !== head.word)
                    report_mismatch("digest_word", head.word, m_tdata[31:0]);
                if (m_tdata[33:32] !== head.index)
                    report_mismatch("word_index", 32'(head.index), 32'(m_tdata[33:32]));
                if (m_tlast !== head.is_last)
                    report_mismatch("last_word", 32'(head.is_last), 32'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("md5_stream_hasher_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = CMD_ABSORB;
        rst_n        = 1'b0;
        error_count  = 0;
        items_sent   = 0;
        burst_left   = 0;
        hold_request = 0;
        cycle_count  = 0;
        load_initial_vector();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_message();
        test_byte_extremes();
        test_random_messages();
        test_output_backpressure();
        s_tvalid <= 1'b0;
        while (pending_digest_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("md5_stream_hasher_tb: PASS");
        else
            $display("md5_stream_hasher_tb: FAIL");
        $finish;
    end

endmodule
